// ===== hw/rtl/nsp_pkg.sv =====
// Shared types, constants and lookup functions for the NMEA sentence nibble packer.
`timescale 1ns / 1ps

package nsp_pkg;

    // Header length, field separator and the end-of-field nibble
    localparam logic [2:0] HDR_LEN   = 3'd7;
    localparam logic [7:0] CHAR_SEP  = 8'h2C;
    localparam logic [3:0] NIB_END   = 4'hF;

    // Known sentence types, in header priority order
    localparam logic [1:0] TYPE_RMC = 2'd0;
    localparam logic [1:0] TYPE_GGA = 2'd1;
    localparam logic [1:0] TYPE_GSA = 2'd2;
    localparam logic [1:0] TYPE_VTG = 2'd3;

    // Field kind maps: bit n set means field n is a digit (Q) field
    localparam logic [31:0] QMAP_RMC = 32'h0000_03D5;  // QBQBQBQQQQB
    localparam logic [31:0] QMAP_GGA = 32'h0000_05EB;  // QQBQBQQQQBQBBB
    localparam logic [31:0] QMAP_GSA = 32'h0001_FFFE;  // BQQQQQQQQQQQQQQQQ
    localparam logic [31:0] QMAP_VTG = 32'h0000_0055;  // QBQBQBQB

    // One queued result transfer
    typedef struct packed {
        logic       ovf;
        logic       unk;
        logic       fin;
        logic [5:0] idx;
        logic [7:0] data;
    } res_t;

    // Expected header character for a type at a header position
    function automatic logic [7:0] hdr_char(logic [1:0] stype, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (pos)
            3'd0: ch = "$";
            3'd1: ch = "G";
            3'd2: ch = "P";
            3'd3: begin
                unique case (stype)
                    TYPE_RMC: ch = "R";
                    TYPE_GGA: ch = "G";
                    TYPE_GSA: ch = "G";
                    TYPE_VTG: ch = "V";
                    default:  ch = 8'h00;
                endcase
            end
            3'd4: begin
                unique case (stype)
                    TYPE_RMC: ch = "M";
                    TYPE_GGA: ch = "G";
                    TYPE_GSA: ch = "S";
                    TYPE_VTG: ch = "T";
                    default:  ch = 8'h00;
                endcase
            end
            3'd5: begin
                unique case (stype)
                    TYPE_RMC: ch = "C";
                    TYPE_GGA: ch = "A";
                    TYPE_GSA: ch = "A";
                    TYPE_VTG: ch = "G";
                    default:  ch = 8'h00;
                endcase
            end
            3'd6: ch = ",";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // True when the field is a digit field for the type; fields past the map are B
    function automatic logic field_is_q(logic [1:0] stype, logic [4:0] field);
        logic [31:0] qmap;
        qmap = QMAP_RMC;
        unique case (stype)
            TYPE_RMC: qmap = QMAP_RMC;
            TYPE_GGA: qmap = QMAP_GGA;
            TYPE_GSA: qmap = QMAP_GSA;
            TYPE_VTG: qmap = QMAP_VTG;
            default:  qmap = QMAP_RMC;
        endcase
        return qmap[field];
    endfunction

endpackage

// ===== hw/rtl/nmea_sentence_nibble_packer_unit.sv =====
// Top level of the NMEA sentence nibble packer: header match, field packing, result queue.
`timescale 1ns / 1ps

// Usage
//   Slave channel s_*: one sentence character per transfer in s_tdata, s_tlast on the
//   final character. The next transfer after s_tlast starts a new sentence.
//   Master channel m_*: packed record bytes. m_tdata holds the byte and its index,
//   m_tlast marks the last result of a sentence, m_tuser flags an unknown header
//   and dropped nibbles past the RECORD_BYTES capacity.
// Output: a character's first result reaches m_* in the cycle after its transfer when the
//   queue is empty; results already queued ahead of it are sent first.
// Throughput: one character per cycle while s_tready is high. Packing is one combinational
//   pass from the sentence state registers into a three-entry result queue; a character
//   gives zero, one or two results, and each m_* transfer sends one result, so the rate
//   holds while the results average at most one per character.
// Stalls: s_tready stays high while the queue can take two more results after the
//   current output transfer, so a stalled m_* side holds s_* as the queue fills.
// Reset: aresetn (synchronous, active low) empties the queue and returns the
//   sentence state to the start of a sentence.
module nmea_sentence_nibble_packer_unit #(
    parameter int RECORD_BYTES = 56
) (
    input  logic        aclk,
    input  logic        aresetn,
    // character
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // end_of_sentence
    // packed record bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] packed_byte, [13:8] byte_index, [15:14] zero
    output logic        m_tlast,   // final_result
    output logic [1:0]  m_tuser    // [0] unknown_type, [1] record_overflow
);

    localparam int NCW = $clog2(2 * RECORD_BYTES + 1);
    localparam logic [NCW-1:0] CAP = NCW'(2 * RECORD_BYTES);

    typedef struct packed {
        logic [NCW-1:0] count;
        logic [3:0]     pend;
        logic           ovf;
        logic           emit;
        logic [7:0]     data;
        logic [5:0]     idx;
    } push_t;

    // Push one nibble into the record (or flag overflow when full); emit a byte when it completes a pair
    function automatic push_t push_nib(push_t s, logic en, logic [3:0] nib);
        push_t r;
        r      = s;
        r.emit = 1'b0;
        r.data = '0;
        r.idx  = '0;
        if (en) begin
            if (s.count >= CAP) begin
                r.ovf = 1'b1;
            end else if (!s.count[0]) begin
                r.pend  = nib;
                r.count = s.count + 1'b1;
            end else begin
                r.emit  = 1'b1;
                r.data  = {nib, s.pend};
                r.idx   = 6'(s.count >> 1);
                r.pend  = 4'h0;
                r.count = s.count + 1'b1;
            end
        end
        return r;
    endfunction

    // Sentence state
    logic [2:0]     hpos_reg,   hpos_next;
    logic [3:0]     flags_reg,  flags_next;
    logic [1:0]     stype_reg,  stype_next;
    logic [4:0]     field_reg,  field_next;
    logic [NCW-1:0] ncount_reg, ncount_next;
    logic [3:0]     pend_reg,   pend_next;
    logic           ovf_reg,    ovf_next;

    // Result queue, entry 0 is on the master port
    nsp_pkg::res_t q_reg [3];
    nsp_pkg::res_t q_next [3];
    logic [1:0]    cnt_reg, cnt_next;

    logic          s_xfer, m_xfer;
    logic [3:0]    hdr_hit, flags_m;
    logic          in_hdr, is_q, known, unk_res, eos_known, part_res, stat_res;
    logic [1:0]    nib_cnt, stype_found, n_res, base;
    logic [3:0]    nib0, nib1;
    push_t         p0, p1, p2;
    nsp_pkg::res_t res0, res1, r_push, r_part, r_stat;

    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= 2'd1) || ((cnt_reg == 2'd2) && m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    // Compare the character against every header at the current position
    always_comb begin
        for (int t = 0; t < 4; t++) begin
            hdr_hit[t] = (nsp_pkg::hdr_char(2'(t), hpos_reg) == s_tdata);
        end
        flags_m = flags_reg & hdr_hit;
        priority if (flags_m[0]) stype_found = nsp_pkg::TYPE_RMC;
        else if (flags_m[1])     stype_found = nsp_pkg::TYPE_GGA;
        else if (flags_m[2])     stype_found = nsp_pkg::TYPE_GSA;
        else                     stype_found = nsp_pkg::TYPE_VTG;
    end

    assign in_hdr = (hpos_reg != nsp_pkg::HDR_LEN);
    assign is_q   = nsp_pkg::field_is_q(stype_reg, field_reg);

    // Decode the character into nibbles and the next header and field state
    always_comb begin
        hpos_next  = hpos_reg;
        flags_next = flags_reg;
        stype_next = stype_reg;
        field_next = field_reg;
        known      = 1'b0;
        unk_res    = 1'b0;
        nib_cnt    = 2'd0;
        nib0       = 4'h0;
        nib1       = 4'h0;
        if (in_hdr) begin
            hpos_next  = hpos_reg + 3'd1;
            flags_next = flags_m;
            if ((hpos_next == nsp_pkg::HDR_LEN) && (flags_m != 4'h0)) begin
                stype_next = stype_found;
                nib_cnt    = 2'd1;
                nib0       = {2'b00, stype_found};
                known      = 1'b1;
            end else if ((hpos_next == nsp_pkg::HDR_LEN) || s_tlast) begin
                hpos_next  = nsp_pkg::HDR_LEN;
                flags_next = 4'h0;
                unk_res    = 1'b1;
            end
        end else if (flags_reg != 4'h0) begin
            known = 1'b1;
            if (s_tdata == nsp_pkg::CHAR_SEP) begin
                nib_cnt = is_q ? 2'd1 : 2'd2;
                nib0    = nsp_pkg::NIB_END;
                nib1    = nsp_pkg::NIB_END;
                if (field_reg != 5'd31) begin
                    field_next = field_reg + 5'd1;
                end
            end else if (is_q) begin
                // digits and (char - 0x20) mod 16 both reduce to the low nibble
                nib_cnt = 2'd1;
                nib0    = s_tdata[3:0];
            end else begin
                nib_cnt = 2'd2;
                nib0    = s_tdata[3:0];
                nib1    = s_tdata[7:4];
            end
        end
    end

    // Pack the nibbles and collect this character's results
    always_comb begin
        p0       = '0;
        p0.count = ncount_reg;
        p0.pend  = pend_reg;
        p0.ovf   = ovf_reg;
        p1       = push_nib(p0, nib_cnt != 2'd0, nib0);
        p2       = push_nib(p1, nib_cnt == 2'd2, nib1);

        eos_known = s_tlast && known;

        r_push      = '0;
        r_push.ovf  = p2.ovf;
        r_push.data = p1.emit ? p1.data : p2.data;
        r_push.idx  = p1.emit ? p1.idx  : p2.idx;

        part_res    = eos_known && p2.count[0];
        r_part      = '0;
        r_part.ovf  = p2.ovf;
        r_part.fin  = 1'b1;
        r_part.data = {4'h0, p2.pend};
        r_part.idx  = 6'(p2.count >> 1);

        stat_res    = eos_known && !(p1.emit || p2.emit) && !part_res;
        r_stat      = '0;
        r_stat.ovf  = p2.ovf;
        r_stat.fin  = 1'b1;

        res0  = '0;
        res1  = r_part;
        n_res = 2'd0;
        if (unk_res) begin
            res0.unk = 1'b1;
            res0.fin = 1'b1;
            n_res    = 2'd1;
        end else if (p1.emit || p2.emit) begin
            res0     = r_push;
            res0.fin = s_tlast && !part_res;
            n_res    = part_res ? 2'd2 : 2'd1;
        end else if (part_res) begin
            res0  = r_part;
            n_res = 2'd1;
        end else if (stat_res) begin
            res0  = r_stat;
            n_res = 2'd1;
        end
    end

    // Drop the sent entry and append the new results behind the rest
    always_comb begin
        base = m_xfer ? (cnt_reg - 2'd1) : cnt_reg;
        if (m_xfer) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            q_next[2] = q_reg[2];
        end else begin
            q_next[0] = q_reg[0];
            q_next[1] = q_reg[1];
            q_next[2] = q_reg[2];
        end
        cnt_next = base;
        if (s_xfer) begin
            for (int i = 0; i < 3; i++) begin
                if ((n_res != 2'd0) && (base == 2'(i))) begin
                    q_next[i] = res0;
                end
                if ((n_res == 2'd2) && ((base + 2'd1) == 2'(i))) begin
                    q_next[i] = res1;
                end
            end
            cnt_next = base + n_res;
        end
    end

    // Update sentence state and queue fill; clear the sentence after its last character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hpos_reg   <= 3'd0;
            flags_reg  <= 4'hF;
            stype_reg  <= nsp_pkg::TYPE_RMC;
            field_reg  <= 5'd0;
            ncount_reg <= '0;
            pend_reg   <= 4'h0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_xfer) begin
                if (s_tlast) begin
                    hpos_reg   <= 3'd0;
                    flags_reg  <= 4'hF;
                    stype_reg  <= nsp_pkg::TYPE_RMC;
                    field_reg  <= 5'd0;
                    ncount_reg <= '0;
                    pend_reg   <= 4'h0;
                    ovf_reg    <= 1'b0;
                end else begin
                    hpos_reg   <= hpos_next;
                    flags_reg  <= flags_next;
                    stype_reg  <= stype_next;
                    field_reg  <= field_next;
                    ncount_reg <= p2.count;
                    pend_reg   <= p2.pend;
                    ovf_reg    <= p2.ovf;
                end
            end
        end
    end

    // Hold queue payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // Drive the master port from the queue head
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {2'b00, q_reg[0].idx, q_reg[0].data};
    assign m_tlast  = q_reg[0].fin;
    assign m_tuser  = {q_reg[0].ovf, q_reg[0].unk};

`ifndef SYNTH
    // An unknown-type result always closes its sentence and never reports overflow
    a_unk_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
        else $error("unknown-type result without tlast or with overflow");

    // No nibble is counted while the header is still being matched
    a_hdr_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (hpos_reg != nsp_pkg::HDR_LEN) |-> (ncount_reg == '0))
        else $error("nibbles counted during header");

    // The pending half byte is clear whenever the nibble count is even
    a_pend_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !ncount_reg[0] |-> (pend_reg == 4'h0))
        else $error("stale pending nibble");

    // The last character of a sentence returns the state to sentence start
    a_eos_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> ((hpos_reg == 3'd0) && (ncount_reg == '0)
            && (flags_reg == 4'hF) && !ovf_reg))
        else $error("sentence state not cleared after tlast");
`endif

endmodule
